// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL files of the line framer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mlf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlf_pkg
// Types and constants of the meter line framer and checksum unit.
// ----------------------------------------------------------------------------
package mlf_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int POS_W         = $clog2(LINE_CAPACITY);
    localparam int BYTE_W        = 8;
    localparam int CK_W          = 6;
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = $clog2(Q_DEPTH);
    localparam int Q_CW          = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CK_BIAS  = 8'h20;

    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_ONE     = 2'd1;
    localparam logic [1:0] MODE_TWO     = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              line_end;
        logic              line_ok;
    } mlf_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mlf_q_status_t;

endpackage

// ===== rtl/mlf_if.sv =====
// ----------------------------------------------------------------------------
// mlf_if
// Valid/ready channels of the line framer: received bytes and results.
// ----------------------------------------------------------------------------
interface mlf_byte_if import mlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlf_result_if ();
    logic valid;
    logic ready;
    logic is_line_end;

    modport source (output valid, output is_line_end, input ready);
    modport sink   (input valid, input is_line_end, output ready);
endinterface

// ===== rtl/meter_line_framer_checksum_unit.sv =====
// ----------------------------------------------------------------------------
// meter_line_framer_checksum_unit
// Teleinformation line framer with line checksum check.
//
// Channel rx carries one received byte per transfer; channel result carries
// one status bit per transfer: 0 for a byte taken as line data, 1 for a line
// end. CR, NUL, STX and ETX bytes are dropped and give no result. A line ends
// on LF or on a byte arriving at a full line store, which is then dropped.
// cfg_write_en/cfg_write_data write skip_check (1 = no checksum check).
// Throughput: one byte per cycle while the queue is not full. An accepted
// byte passes through the two-entry queue and then the output register,
// which drives result valid. When result stalls, the output register holds
// its result and rx.ready drops once the queue holds two bytes, at most two
// result-giving bytes after the stall begins; no result is lost. Reset
// clears line position, checksum state, detected mode and skip_check, and
// empties the queue and output stage.
// ----------------------------------------------------------------------------
module meter_line_framer_checksum_unit
    import mlf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic         cfg_write_data,
    mlf_byte_if.sink     rx,
    mlf_result_if.source result
);

    mlf_q_status_t q_status;
    mlf_item_t     push_item;
    mlf_item_t     pop_item;
    logic          push;
    logic          pop;

    mlf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    mlf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    mlf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_status       (q_status),
        .pop_item       (pop_item),
        .pop            (pop),
        .result         (result)
    );

endmodule

// ===== rtl/mlf_queue.sv =====
// ----------------------------------------------------------------------------
// mlf_queue
// Two-entry queue between the classifying front and the checksum back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlf_queue
    import mlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mlf_item_t     push_item,
    input  logic          pop,
    output mlf_item_t     pop_item,
    output mlf_q_status_t status
);

    mlf_item_t       entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    assign status.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_CLK(a_no_push_full, !(push && status.full && !pop), "push into full queue")
    `ASSERT_CLK(a_no_pop_empty, !(pop && status.empty), "pop from empty queue")

endmodule

// ===== rtl/mlf_front.sv =====
// ----------------------------------------------------------------------------
// mlf_front
// Accepts received bytes, drops control bytes, tracks line position and
// marks line ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlf_front
    import mlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mlf_byte_if.sink      rx,
    input  mlf_q_status_t q_status,
    output logic          push,
    output mlf_item_t     push_item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;
    logic             drop;

    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        drop = rx.rx_byte inside {BYTE_CR, BYTE_NUL, BYTE_STX, BYTE_ETX};
        push_item.data     = rx.rx_byte;
        push_item.line_end = (rx.rx_byte == BYTE_LF) ||
                             (pos_reg >= POS_W'(LINE_CAPACITY - 1));
        push_item.line_ok  = (pos_reg >= POS_W'(2));
        push = accept && !drop;
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = push_item.line_end ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    `ASSERT_NEXT(a_eol_clears_pos, push && push_item.line_end, pos_reg == '0, "position kept")

endmodule

// ===== rtl/mlf_back.sv =====
// ----------------------------------------------------------------------------
// mlf_back
// Running checksum, mode detection and the registered result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlf_back
    import mlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data,
    input  mlf_q_status_t q_status,
    input  mlf_item_t     pop_item,
    output logic          pop,
    mlf_result_if.source  result
);

    logic              skip_reg;
    logic [CK_W-1:0]   sum_reg;
    logic [CK_W-1:0]   sum_next;
    logic [BYTE_W-1:0] last_reg;
    logic [BYTE_W-1:0] last_next;
    logic [CK_W-1:0]   prev_reg;
    logic [CK_W-1:0]   prev_next;
    logic [1:0]        mode_reg;
    logic [1:0]        mode_next;
    logic              valid_reg;
    logic              valid_next;
    logic              eol_reg;
    logic              eol_next;
    logic [CK_W-1:0]   with_sep;
    logic [BYTE_W-1:0] mode1_ck;
    logic [BYTE_W-1:0] mode2_ck;

    assign result.valid       = valid_reg;
    assign result.is_line_end = eol_reg;
    assign pop = !q_status.empty && (!valid_reg || result.ready);

    always_comb
    begin
        with_sep   = sum_reg - last_reg[CK_W-1:0];
        mode2_ck   = {2'b00, with_sep} + CK_BIAS;
        mode1_ck   = {2'b00, with_sep - prev_reg} + CK_BIAS;
        sum_next   = sum_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        mode_next  = mode_reg;
        valid_next = valid_reg && !result.ready;
        eol_next   = eol_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            eol_next   = pop_item.line_end;
            if (pop_item.line_end)
            begin
                if (!skip_reg && pop_item.line_ok)
                begin
                    if (mode1_ck == last_reg)
                    begin
                        mode_next = MODE_ONE;
                    end
                    else if (mode2_ck == last_reg)
                    begin
                        mode_next = MODE_TWO;
                    end
                end
                sum_next  = '0;
                last_next = '0;
                prev_next = '0;
            end
            else
            begin
                prev_next = last_reg[CK_W-1:0];
                last_next = pop_item.data;
                sum_next  = sum_reg + pop_item.data[CK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b0;
            sum_reg   <= '0;
            last_reg  <= '0;
            prev_reg  <= '0;
            mode_reg  <= MODE_UNKNOWN;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                skip_reg <= cfg_write_data;
            end
            sum_reg   <= sum_next;
            last_reg  <= last_next;
            prev_reg  <= prev_next;
            mode_reg  <= mode_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg <= eol_next;
    end

    `ASSERT_NEXT(a_pop_shows_result, pop, valid_reg, "popped item gave no result")

endmodule
